>>> design/rlmtf_pkg.sv
package rlmtf_pkg;

    // Opcodes of an input word.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Chapter reported when there is no entry.
    localparam logic [30:0] CHAPTER_NONE = 31'd1;

    // Wide enough to hold an entry count of up to 511.
    localparam int COUNT_EXT_W = 9;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        book_id;
        logic signed [31:0] chapter_in;
        logic [31:0]        offset_in;
        logic               title_present;
        logic [3:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [30:0] chapter_out;
        logic [31:0] offset_out;
        logic [31:0] id_out;
        logic [31:0] evicted_id;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] id;
        logic [30:0] chapter;
        logic [31:0] offset;
    } entry_t;

endpackage

>>> design/rlmtf_mem.sv
module rlmtf_mem
    import rlmtf_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    // One write port and one read port; read data is registered and appears in the cycle after re.
    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/recent_list_move_to_front.sv
// Most-recently-used list of keyed entries (id, chapter, offset), most recent first.
// The request channel (req_valid, req_ready, req) takes one word per operation:
// an update, a lookup by id, or a read of the entry at a list position. The
// response channel (rsp_valid, rsp_ready, rsp) returns exactly one word for each
// request, in order.
// Only one request is in work at a time. A read passes through the read-wait and done states;
// a rejected update, the unused opcode and a read beyond the count go straight to done.
// A lookup walks the list through the memory read port, one entry per cycle. An update
// walks the list the same way and then shifts the entries in front of the hit (or all
// of them on an insert into a list that is not full, all but the evicted tail on one
// that is full) down by one place, one entry per cycle through the read and write
// ports, and writes the new entry at the front. The list is held in a single entry
// memory with one read port, so the walk and the shift go one entry at a time.
// The response sits in an output register, so a new request is taken while a
// finished response still waits; a stalled receiver holds the next finished result,
// and with it the request channel, until the waiting word is taken.
// Reset empties the list at once (the count goes to zero); no memory sweep is needed
// since only entries below the count are ever read.
module recent_list_move_to_front
    import rlmtf_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             more_reg, more_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Operation context and datapath registers.
    logic [1:0]       op_reg, op_next;
    logic [31:0]      id_reg, id_next;
    logic [30:0]      chap_reg, chap_next;
    logic [31:0]      off_reg, off_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [31:0]      last_id_reg, last_id_next;
    logic [IDX_W-1:0] src_reg, src_next;
    logic [IDX_W-1:0] dst_reg, dst_next;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    // Memory port signals.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    logic [COUNT_EXT_W-1:0] count_wide;
    logic [COUNT_EXT_W-1:0] pos_wide;
    logic                   list_full;

    assign count_wide = COUNT_EXT_W'(count_reg);
    assign pos_wide   = COUNT_EXT_W'(req.position);
    assign list_full  = (count_reg == CNT_W'(MAX_ENTRIES));

    rlmtf_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    always_comb
    begin
        logic [CNT_W-1:0] moves;
        logic [CNT_W-1:0] moves_m1;
        logic             found;

        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        more_next      = more_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        chap_next      = chap_reg;
        off_next       = off_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        last_id_next   = last_id_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = entry_t'{id: id_reg, chapter: chap_reg, offset: off_reg};
        mem_re    = 1'b0;
        mem_raddr = rd_idx_reg[IDX_W-1:0];

        moves    = '0;
        moves_m1 = '0;
        found    = pend_reg && (mem_rdata.id == id_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    id_next     = req.book_id;
                    off_next    = req.offset_in;
                    // Chapters below one are recorded as one.
                    chap_next   = (req.chapter_in < 32'sd1) ? CHAPTER_NONE
                                                            : req.chapter_in[30:0];
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    res_next    = rsp_t'{status: ST_NOTFOUND, hit: 1'b0,
                                         chapter_out: CHAPTER_NONE, offset_out: '0,
                                         id_out: '0, evicted_id: '0, entry_count: '0};
                    unique case (req.opcode)
                        OP_UPDATE:
                        begin
                            if ((req.book_id == '0) || !req.title_present)
                            begin
                                res_next.status = ST_INVALID;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_next = S_SEARCH;
                        end
                        OP_READ:
                        begin
                            if (pos_wide < count_wide)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_wide[IDX_W-1:0];
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_INVALID;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // Reads are issued back to back; each compare uses the word read
                // in the previous cycle.
                if (pend_reg)
                begin
                    last_id_next = mem_rdata.id;
                end
                if (found)
                begin
                    pend_next = 1'b0;
                    if (op_reg == OP_UPDATE)
                    begin
                        res_next.status      = ST_OK;
                        res_next.hit         = 1'b1;
                        res_next.chapter_out = chap_reg;
                        res_next.offset_out  = off_reg;
                        res_next.id_out      = id_reg;
                        moves                = CNT_W'(cmp_idx_reg);
                        state_next           = S_SHIFT;
                    end
                    else
                    begin
                        res_next.status      = ST_OK;
                        res_next.hit         = 1'b1;
                        res_next.chapter_out = (mem_rdata.chapter == '0) ? CHAPTER_NONE
                                                                         : mem_rdata.chapter;
                        res_next.offset_out  = mem_rdata.offset;
                        res_next.id_out      = id_reg;
                        state_next           = S_DONE;
                    end
                end
                else if (!pend_reg && !(rd_idx_reg < count_reg))
                begin
                    // Whole list compared without a match.
                    if (op_reg == OP_UPDATE)
                    begin
                        res_next.status      = ST_OK;
                        res_next.chapter_out = chap_reg;
                        res_next.offset_out  = off_reg;
                        res_next.id_out      = id_reg;
                        if (list_full)
                        begin
                            // The last word compared was the tail entry.
                            res_next.evicted_id = last_id_reg;
                            moves               = CNT_W'(MAX_ENTRIES - 1);
                        end
                        else
                        begin
                            moves      = count_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (rd_idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = rd_idx_reg[IDX_W-1:0];
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (state_next == S_SHIFT)
                begin
                    moves_m1  = moves - CNT_W'(1);
                    more_next = (moves != '0);
                    src_next  = moves_m1[IDX_W-1:0];
                end
            end

            S_SHIFT:
            begin
                // Entries move down one place, from the deepest one upward, and then the new entry
                // is written at the front; a write lands two places below the read in flight, if any.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                end
                if (more_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    pend_next = 1'b1;
                    dst_next  = src_reg + IDX_W'(1);
                    if (src_reg == '0)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        src_next = src_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        state_next = S_DONE;
                    end
                end
            end

            S_RDWAIT:
            begin
                res_next.status      = ST_OK;
                res_next.chapter_out = mem_rdata.chapter;
                res_next.offset_out  = mem_rdata.offset;
                res_next.id_out      = mem_rdata.id;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next             = res_reg;
                    rsp_data_next.entry_count = count_wide[4:0];
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            more_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            more_reg      <= more_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        chap_reg     <= chap_next;
        off_reg      <= off_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        last_id_reg  <= last_id_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule
